// ===== rtl/tcq_pkg.sv =====
// Package with the shared widths, request codes and cell command type of the timed command queue.
package tcq_pkg;

	localparam int TimeW       = 32;
	localparam int HandleW     = 8;
	localparam int DefaultDepth = 16;
	localparam int DefaultHandleBits = 8;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef logic [TimeW-1:0] time_t;

	typedef struct packed {
		logic  insert;
		logic  pop;
		time_t due;
	} tcq_cmd_t;

endpackage

// ===== rtl/tcq_req_if.sv =====
// Request channel interface of the timed command queue.
interface tcq_req_if
	import tcq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [TimeW-1:0]   due_time;
	logic [HandleW-1:0] command_handle;

	modport source (output valid, req_type, due_time, command_handle, input ready);
	modport sink (input valid, req_type, due_time, command_handle, output ready);
endinterface

// ===== rtl/tcq_rsp_if.sv =====
// Result channel interface of the timed command queue.
interface tcq_rsp_if
	import tcq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               released;
	logic [HandleW-1:0] released_handle;
	logic               insert_refused;
	logic [TimeW-1:0]   now_seconds;
	logic               last_result;

	modport source (output valid, released, released_handle, insert_refused, now_seconds,
		last_result, input ready);
	modport sink (input valid, released, released_handle, insert_refused, now_seconds,
		last_result, output ready);
endinterface

// ===== rtl/tcq_cell.sv =====
// One slot of the sorted queue: holds a due time and a handle and trades them with its neighbors.
module tcq_cell
	import tcq_pkg::*;
#(
	parameter int HANDLE_BITS = DefaultHandleBits
) (
	input  logic                   clk,
	input  tcq_cmd_t               cmd,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic                   occupied,
	input  logic                   prev_keep,
	input  time_t                  prev_time,
	input  logic [HANDLE_BITS-1:0] prev_handle,
	input  time_t                  next_time,
	input  logic [HANDLE_BITS-1:0] next_handle,
	output time_t                  etime,
	output logic [HANDLE_BITS-1:0] handle,
	output logic                   keep
);

	time_t                  etime_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// An occupied slot due no later than the new entry stays; the kept slots form a prefix.
	assign keep   = occupied && (etime_q <= cmd.due);
	assign etime  = etime_q;
	assign handle = handle_q;

	always_ff @(posedge clk) begin
		if (cmd.insert && !keep) begin
			if (prev_keep) begin
				etime_q  <= cmd.due;
				handle_q <= new_handle;
			end else begin
				etime_q  <= prev_time;
				handle_q <= prev_handle;
			end
		end else if (cmd.pop) begin
			etime_q  <= next_time;
			handle_q <= next_handle;
		end
	end

endmodule

// ===== rtl/timed_command_queue.sv =====
// Top level of the timed command queue: a sorted row of slots with its control and result register.
//
// Requests arrive on req: an insert carries a due second and a command handle, a tick
// advances time. Results leave on rsp, each with its valid/ready handshake.
// An insert gives one result, registered in the cycle after acceptance; it is refused and flagged
// when all QUEUE_DEPTH slots are full. A tick copies the next-second counter into the current
// second and increments the counter; its first result is produced once the block has entered
// the release state and the result register has loaded, and after that one slot leaves the head
// per cycle while rsp.ready stays high. A tick that finds nothing due gives one empty result. The
// last result of a request is marked by last_result. A new request is taken only once all
// results of the previous one have been produced and the result register is free. Writing
// cfg_wdata with cfg_we loads the next-second counter; the user must do this only while the
// block is idle, and the block itself does not enforce it. Reset clears the slot count, both
// second counters and the result valid flag; the slot contents need no reset. When the
// receiver holds rsp.ready low, the pending result holds and the queue waits without losing
// or repeating anything.
module timed_command_queue
	import tcq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DefaultDepth,
	parameter int HANDLE_BITS = DefaultHandleBits
) (
	input  logic        clk,
	input  logic        arst_n,
	tcq_req_if.sink     req,
	tcq_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  time_t       cfg_wdata
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_REL  = 1'b1;

	logic                   state_q;
	logic [CntW-1:0]        count_q;
	time_t                  cur_q;
	time_t                  next_q;

	logic                   out_valid_q;
	logic                   released_q;
	logic [HandleW-1:0]     handle_out_q;
	logic                   refused_q;
	time_t                  now_q;
	logic                   last_q;

	tcq_cmd_t               cmd;
	logic [HANDLE_BITS-1:0] new_handle;
	logic [HandleW-1:0]     head_handle_out;
	time_t                  cell_time [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] cell_handle [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_keep;
	logic [QUEUE_DEPTH-1:0] occ;

	logic out_free;
	logic accept;
	logic full;
	logic head_due;
	logic second_due;

	assign out_free   = !out_valid_q || rsp.ready;
	assign req.ready  = (state_q == ST_IDLE) && out_free;
	assign accept     = req.valid && req.ready;
	assign full       = (count_q == CntW'(QUEUE_DEPTH));
	assign head_due   = occ[0] && (cell_time[0] <= cur_q);
	assign second_due = occ[1] && (cell_time[1] <= cur_q);

	assign cmd.insert = accept && (req.req_type == REQ_INSERT) && !full;
	assign cmd.pop    = (state_q == ST_REL) && out_free && head_due;
	assign cmd.due    = req.due_time;

	generate
		if (HANDLE_BITS <= HandleW) begin : g_hin_narrow
			assign new_handle = req.command_handle[HANDLE_BITS-1:0];
		end else begin : g_hin_wide
			assign new_handle = {{(HANDLE_BITS-HandleW){1'b0}}, req.command_handle};
		end
		if (HANDLE_BITS >= HandleW) begin : g_hout_narrow
			assign head_handle_out = cell_handle[0][HandleW-1:0];
		end else begin : g_hout_wide
			assign head_handle_out = {{(HandleW-HANDLE_BITS){1'b0}}, cell_handle[0]};
		end
	endgenerate

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			assign occ[gi] = (CntW'(gi) < count_q);
			if (gi == 0) begin : g_first
				tcq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
					.clk         (clk),
					.cmd         (cmd),
					.new_handle  (new_handle),
					.occupied    (occ[gi]),
					.prev_keep   (1'b1),
					.prev_time   (cmd.due),
					.prev_handle (new_handle),
					.next_time   (cell_time[gi+1]),
					.next_handle (cell_handle[gi+1]),
					.etime       (cell_time[gi]),
					.handle      (cell_handle[gi]),
					.keep        (cell_keep[gi])
				);
			end else if (gi == QUEUE_DEPTH - 1) begin : g_last
				tcq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
					.clk         (clk),
					.cmd         (cmd),
					.new_handle  (new_handle),
					.occupied    (occ[gi]),
					.prev_keep   (cell_keep[gi-1]),
					.prev_time   (cell_time[gi-1]),
					.prev_handle (cell_handle[gi-1]),
					.next_time   (cell_time[gi]),
					.next_handle (cell_handle[gi]),
					.etime       (cell_time[gi]),
					.handle      (cell_handle[gi]),
					.keep        (cell_keep[gi])
				);
			end else begin : g_mid
				tcq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
					.clk         (clk),
					.cmd         (cmd),
					.new_handle  (new_handle),
					.occupied    (occ[gi]),
					.prev_keep   (cell_keep[gi-1]),
					.prev_time   (cell_time[gi-1]),
					.prev_handle (cell_handle[gi-1]),
					.next_time   (cell_time[gi+1]),
					.next_handle (cell_handle[gi+1]),
					.etime       (cell_time[gi]),
					.handle      (cell_handle[gi]),
					.keep        (cell_keep[gi])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			next_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				next_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_TICK) begin
							cur_q   <= next_q;
							next_q  <= next_q + 1'b1;
							state_q <= ST_REL;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
						end
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_REL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (head_due) begin
							count_q <= count_q - 1'b1;
							if (!second_due) begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; loaded whenever a new result is produced.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && req.req_type == REQ_INSERT) begin
			released_q   <= 1'b0;
			handle_out_q <= '0;
			refused_q    <= full;
			now_q        <= cur_q;
			last_q       <= 1'b1;
		end else if (state_q == ST_REL && out_free) begin
			released_q   <= head_due;
			handle_out_q <= head_due ? head_handle_out : '0;
			refused_q    <= 1'b0;
			now_q        <= cur_q;
			last_q       <= !(head_due && second_due);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.released        = released_q;
	assign rsp.released_handle = handle_out_q;
	assign rsp.insert_refused  = refused_q;
	assign rsp.now_seconds     = now_q;
	assign rsp.last_result     = last_q;

endmodule
